/* design/swad_pkg.sv */
// Shared types and constants for the sliding window aggregate deque.
// Used by the top level, swad_combine and the testbench; depends on nothing else.
package swad_pkg;

    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD = 2'd0,
        MODE_MIN = 2'd1,
        MODE_MAX = 2'd2,
        MODE_XOR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_POP_WAIT,
        S_COPY,
        S_DONE
    } state_t;

endpackage

/* design/sliding_window_aggregate_deque_unit.sv */
// Top level of the sliding window aggregate deque: control sequencer and stack state.
// Depends on swad_pkg, swad_ram and swad_combine.
//
// The deque is held as two stacks, each in its own RAM that stores a value and
// its running fold per entry; the top fold of each stack is cached in a register.
// One transfer is processed at a time. A push, a clear, an ignored operation and
// a pop that leaves its side empty or finds the deque empty go from the execute
// state straight to the done state, which registers the result once the output
// is free. A pop that leaves values on its side first re-reads the new top fold
// from RAM through the read and wait states. A pop on an empty side while two or
// more values are held rebuilds both stacks by streaming the other stack's RAM
// one entry per cycle, followed by the top fold re-read when the popped side
// still holds a value afterward; this cost is amortized over the pops it
// enables. A new transfer is accepted while a finished result is still waiting
// on the output; the following result waits until that one is taken.
module sliding_window_aggregate_deque_unit #(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [swad_pkg::MODE_W-1:0]          cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: opcode[2:0], value[34:3], zero fill.
    input  logic [swad_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: aggregate[31:0], count[42:32], status[44:43], zero fill.
    output logic [swad_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int CW = swad_pkg::COUNT_W;
    localparam int XW = swad_pkg::DATA_W;
    localparam int OW = swad_pkg::OPCODE_W;
    localparam int PAD = swad_pkg::OUT_TDATA_W - XW - CW - swad_pkg::STATUS_W;

    swad_pkg::state_t  state_reg, state_next;
    swad_pkg::mode_t   mode_reg;
    swad_pkg::opcode_t op_reg, op_next;
    logic [VW-1:0]     val_reg, val_next;
    logic [DW-1:0]     fd_reg, fd_next, bd_reg, bd_next;
    logic [VW-1:0]     ftop_reg, ftop_next, btop_reg, btop_next;
    logic              pop_side_reg, pop_side_next;
    logic              phase_reg, phase_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic              pend_reg, pend_next;
    logic [DW-1:0]     len_a_reg, len_a_next, len_b_reg, len_b_next;
    swad_pkg::status_t status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic [XW-1:0]     agg_reg, agg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    swad_pkg::status_t ost_reg, ost_next;

    logic              f_we, b_we;
    logic [AW-1:0]     f_waddr, b_waddr, f_raddr, b_raddr;
    logic [2*VW-1:0]   f_wdata, b_wdata, f_rdata, b_rdata;

    logic [VW-1:0]     ident, ftop_id, btop_id, ca, cb, cres, cfold, src_val;
    logic [DW-1:0]     total, side_depth, other_depth, side_dm1, half;
    logic              is_pop, pop_is_back, wr_side, copy_last, out_free;

    swad_ram #(.WIDTH(2 * VW), .DEPTH(CAPACITY)) u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    swad_ram #(.WIDTH(2 * VW), .DEPTH(CAPACITY)) u_back_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    swad_combine #(.WIDTH(VW)) u_combine (
        .mode (mode_reg),
        .a    (ca),
        .b    (cb),
        .y    (cres)
    );

    assign ident   = (mode_reg == swad_pkg::MODE_MIN) ? {VW{1'b1}} : {VW{1'b0}};
    assign ftop_id = (fd_reg != '0) ? ftop_reg : ident;
    assign btop_id = (bd_reg != '0) ? btop_reg : ident;
    assign total   = fd_reg + bd_reg;

    assign is_pop      = (op_reg == swad_pkg::OP_POP_FRONT) || (op_reg == swad_pkg::OP_POP_BACK);
    assign pop_is_back = (op_reg == swad_pkg::OP_POP_BACK);
    assign side_depth  = pop_is_back ? bd_reg : fd_reg;
    assign other_depth = pop_is_back ? fd_reg : bd_reg;
    assign half        = other_depth >> 1;
    assign side_dm1    = (pop_side_reg ? bd_reg : fd_reg) - 1'b1;

    assign src_val   = pop_side_reg ? f_rdata[VW-1:0] : b_rdata[VW-1:0];
    assign wr_side   = phase_reg ? ~pop_side_reg : pop_side_reg;
    assign cfold     = (wr_ptr_reg == '0) ? src_val : cres;
    assign copy_last = pend_reg && (rem_reg == '0);
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == swad_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD{1'b0}}, ost_reg, cnt_reg, agg_reg};

    always_comb
    begin
        ca = ftop_id;
        cb = btop_id;
        case (state_reg)
            swad_pkg::S_EXEC:
            begin
                if (op_reg == swad_pkg::OP_PUSH_FRONT)
                begin
                    ca = val_reg;
                    cb = ftop_id;
                end
                else
                begin
                    ca = btop_id;
                    cb = val_reg;
                end
            end
            swad_pkg::S_COPY:
            begin
                if (!wr_side)
                begin
                    ca = src_val;
                    cb = ftop_reg;
                end
                else
                begin
                    ca = btop_reg;
                    cb = src_val;
                end
            end
            default:
            begin
                ca = ftop_id;
                cb = btop_id;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swad_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = swad_pkg::S_EXEC;
                end
            end
            swad_pkg::S_EXEC:
            begin
                if (is_pop && total >= DW'(2) && side_depth == '0)
                begin
                    state_next = swad_pkg::S_COPY;
                end
                else if (is_pop && total >= DW'(2) && side_depth >= DW'(2))
                begin
                    state_next = swad_pkg::S_POP_RD;
                end
                else
                begin
                    state_next = swad_pkg::S_DONE;
                end
            end
            swad_pkg::S_POP_RD:   state_next = swad_pkg::S_POP_WAIT;
            swad_pkg::S_POP_WAIT: state_next = swad_pkg::S_DONE;
            swad_pkg::S_COPY:
            begin
                if (copy_last && phase_reg)
                begin
                    state_next = (len_a_reg >= DW'(2)) ? swad_pkg::S_POP_RD : swad_pkg::S_DONE;
                end
            end
            swad_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = swad_pkg::S_IDLE;
                end
            end
            default: state_next = swad_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        val_next       = val_reg;
        fd_next        = fd_reg;
        bd_next        = bd_reg;
        ftop_next      = ftop_reg;
        btop_next      = btop_reg;
        pop_side_next  = pop_side_reg;
        phase_next     = phase_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        status_next    = status_reg;
        agg_next       = agg_reg;
        cnt_next       = cnt_reg;
        ost_next       = ost_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        f_we    = 1'b0;
        b_we    = 1'b0;
        f_waddr = '0;
        b_waddr = '0;
        f_wdata = '0;
        b_wdata = '0;
        f_raddr = '0;
        b_raddr = '0;

        case (state_reg)
            swad_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next  = swad_pkg::opcode_t'(s_axis_tdata[OW-1:0]);
                    val_next = VW'(s_axis_tdata[OW+XW-1:OW]);
                end
            end
            swad_pkg::S_EXEC:
            begin
                status_next = swad_pkg::ST_OK;
                case (op_reg)
                    swad_pkg::OP_PUSH_FRONT, swad_pkg::OP_PUSH_BACK:
                    begin
                        if (total >= DW'(CAPACITY))
                        begin
                            status_next = swad_pkg::ST_FULL;
                        end
                        else if (op_reg == swad_pkg::OP_PUSH_FRONT)
                        begin
                            f_we      = 1'b1;
                            f_waddr   = fd_reg[AW-1:0];
                            f_wdata   = {cres, val_reg};
                            ftop_next = cres;
                            fd_next   = fd_reg + 1'b1;
                        end
                        else
                        begin
                            b_we      = 1'b1;
                            b_waddr   = bd_reg[AW-1:0];
                            b_wdata   = {cres, val_reg};
                            btop_next = cres;
                            bd_next   = bd_reg + 1'b1;
                        end
                    end
                    swad_pkg::OP_POP_FRONT, swad_pkg::OP_POP_BACK:
                    begin
                        pop_side_next = pop_is_back;
                        if (total == '0)
                        begin
                            status_next = swad_pkg::ST_EMPTY;
                        end
                        else if (total == DW'(1))
                        begin
                            fd_next = '0;
                            bd_next = '0;
                        end
                        else if (side_depth != '0)
                        begin
                            if (pop_is_back)
                            begin
                                bd_next = bd_reg - 1'b1;
                            end
                            else
                            begin
                                fd_next = fd_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            if (pop_is_back)
                            begin
                                len_a_next = other_depth - half;
                                len_b_next = half;
                                rd_ptr_next = AW'(other_depth - half - 1'b1);
                            end
                            else
                            begin
                                len_a_next = half;
                                len_b_next = other_depth - half;
                                rd_ptr_next = AW'(half - 1'b1);
                            end
                            rem_next    = pop_is_back ? (other_depth - half) : half;
                            phase_next  = 1'b0;
                            wr_ptr_next = '0;
                            pend_next   = 1'b0;
                        end
                    end
                    swad_pkg::OP_CLEAR:
                    begin
                        fd_next = '0;
                        bd_next = '0;
                    end
                    default:
                    begin
                        fd_next = fd_reg;
                    end
                endcase
            end
            swad_pkg::S_POP_RD:
            begin
                f_raddr = side_dm1[AW-1:0];
                b_raddr = side_dm1[AW-1:0];
            end
            swad_pkg::S_POP_WAIT:
            begin
                if (pop_side_reg)
                begin
                    btop_next = b_rdata[2*VW-1:VW];
                end
                else
                begin
                    ftop_next = f_rdata[2*VW-1:VW];
                end
            end
            swad_pkg::S_COPY:
            begin
                f_raddr = rd_ptr_reg;
                b_raddr = rd_ptr_reg;
                if (pend_reg)
                begin
                    if (!wr_side)
                    begin
                        f_we      = 1'b1;
                        f_waddr   = wr_ptr_reg;
                        f_wdata   = {cfold, src_val};
                        ftop_next = cfold;
                    end
                    else
                    begin
                        b_we      = 1'b1;
                        b_waddr   = wr_ptr_reg;
                        b_wdata   = {cfold, src_val};
                        btop_next = cfold;
                    end
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (rem_reg != '0)
                begin
                    rd_ptr_next = phase_reg ? (rd_ptr_reg + 1'b1) : (rd_ptr_reg - 1'b1);
                    rem_next    = rem_reg - 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (copy_last)
                begin
                    if (!phase_reg)
                    begin
                        phase_next  = 1'b1;
                        rem_next    = len_b_reg;
                        rd_ptr_next = len_a_reg[AW-1:0];
                        wr_ptr_next = '0;
                        pend_next   = 1'b0;
                    end
                    else if (pop_side_reg)
                    begin
                        bd_next = len_a_reg - 1'b1;
                        fd_next = len_b_reg;
                    end
                    else
                    begin
                        fd_next = len_a_reg - 1'b1;
                        bd_next = len_b_reg;
                    end
                end
            end
            swad_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    agg_next       = XW'(cres);
                    cnt_next       = CW'(total);
                    ost_next       = status_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swad_pkg::S_IDLE;
            mode_reg      <= swad_pkg::MODE_ADD;
            fd_reg        <= '0;
            bd_reg        <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            pop_side_reg  <= 1'b0;
            rem_reg       <= '0;
            status_reg    <= swad_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            fd_reg        <= fd_next;
            bd_reg        <= bd_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
            pop_side_reg  <= pop_side_next;
            rem_reg       <= rem_next;
            status_reg    <= status_next;
            if (cfg_wr_en)
            begin
                mode_reg <= swad_pkg::mode_t'(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        ftop_reg   <= ftop_next;
        btop_reg   <= btop_next;
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        len_a_reg  <= len_a_next;
        len_b_reg  <= len_b_next;
        agg_reg    <= agg_next;
        cnt_reg    <= cnt_next;
        ost_reg    <= ost_next;
    end

endmodule

/* design/swad_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing else.
module swad_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/swad_combine.sv */
// Fold operator of the deque: wrapping add, unsigned min, unsigned max or xor.
// Depends on swad_pkg.
module swad_combine #(
    parameter int WIDTH = 32
) (
    input  swad_pkg::mode_t   mode,
    input  logic [WIDTH-1:0]  a,
    input  logic [WIDTH-1:0]  b,
    output logic [WIDTH-1:0]  y
);

    always_comb
    begin
        case (mode)
            swad_pkg::MODE_ADD: y = a + b;
            swad_pkg::MODE_MIN: y = (a < b) ? a : b;
            swad_pkg::MODE_MAX: y = (a > b) ? a : b;
            swad_pkg::MODE_XOR: y = a ^ b;
            default:            y = a ^ b;
        endcase
    end

endmodule

/* tb/sliding_window_aggregate_deque_unit_test.sv */
// Self-checking testbench for the sliding window aggregate deque unit.
// Depends on swad_pkg and the top level sliding_window_aggregate_deque_unit.
// Directed table rows and random traffic are checked against a deque predictor.
`timescale 1ns / 1ps

module sliding_window_aggregate_deque_unit_test;

    localparam int CAP = 1024;

    typedef struct packed {
        logic [swad_pkg::DATA_W-1:0]   aggregate;
        logic [swad_pkg::COUNT_W-1:0]  count;
        logic [swad_pkg::STATUS_W-1:0] status;
    } result_t;

    typedef struct {
        logic [swad_pkg::OPCODE_W-1:0] opcode;
        logic [swad_pkg::DATA_W-1:0]   value;
        bit                            typed;
        result_t                       want;
    } row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [swad_pkg::MODE_W-1:0]      cfg_wr_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [swad_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [swad_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    sliding_window_aggregate_deque_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    swad_pkg::mode_t             mode;
    logic [swad_pkg::DATA_W-1:0] front_vals [CAP];
    logic [swad_pkg::DATA_W-1:0] back_vals [CAP];
    logic [swad_pkg::DATA_W-1:0] front_folds [CAP];
    logic [swad_pkg::DATA_W-1:0] back_folds [CAP];
    logic [swad_pkg::DATA_W-1:0] line_vals [2*CAP];
    int                          front_n;
    int                          back_n;
    result_t                     pending_results [$];
    int                          errors;
    int                          send_idle_pct;
    int                          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [swad_pkg::DATA_W-1:0] unit_value();
        return (mode == swad_pkg::MODE_MIN) ? '1 : '0;
    endfunction

    function automatic logic [swad_pkg::DATA_W-1:0] merge(logic [swad_pkg::DATA_W-1:0] a,
                                                          logic [swad_pkg::DATA_W-1:0] b);
        case (mode)
            swad_pkg::MODE_ADD: return a + b;
            swad_pkg::MODE_MIN: return (a < b) ? a : b;
            swad_pkg::MODE_MAX: return (a > b) ? a : b;
            default:            return a ^ b;
        endcase
    endfunction

    function automatic logic [swad_pkg::DATA_W-1:0] front_fold();
        return front_n ? front_folds[front_n-1] : unit_value();
    endfunction

    function automatic logic [swad_pkg::DATA_W-1:0] back_fold();
        return back_n ? back_folds[back_n-1] : unit_value();
    endfunction

    function automatic void push_front_stack(logic [swad_pkg::DATA_W-1:0] v);
        front_folds[front_n] = merge(v, front_fold());
        front_vals[front_n] = v;
        front_n++;
    endfunction

    function automatic void push_back_stack(logic [swad_pkg::DATA_W-1:0] v);
        back_folds[back_n] = merge(back_fold(), v);
        back_vals[back_n] = v;
        back_n++;
    endfunction

    function automatic void split_evenly();
        int n;
        int half;
        n = 0;
        for (int i = front_n; i > 0; i--)
        begin
            line_vals[n] = front_vals[i-1];
            n++;
        end
        for (int i = 0; i < back_n; i++)
        begin
            line_vals[n] = back_vals[i];
            n++;
        end
        front_n = 0;
        back_n = 0;
        half = n / 2;
        for (int i = half; i > 0; i--)
            push_front_stack(line_vals[i-1]);
        for (int i = half; i < n; i++)
            push_back_stack(line_vals[i]);
    endfunction

    function automatic result_t predict_deque(logic [swad_pkg::OPCODE_W-1:0] op,
                                              logic [swad_pkg::DATA_W-1:0] v);
        result_t r;
        int      total;
        total = front_n + back_n;
        r.status = swad_pkg::ST_OK;
        case (op)
            swad_pkg::OP_PUSH_FRONT, swad_pkg::OP_PUSH_BACK:
            begin
                if (total >= CAP)
                    r.status = swad_pkg::ST_FULL;
                else if (op == swad_pkg::OP_PUSH_FRONT)
                    push_front_stack(v);
                else
                    push_back_stack(v);
            end
            swad_pkg::OP_POP_FRONT, swad_pkg::OP_POP_BACK:
            begin
                if (total == 0)
                    r.status = swad_pkg::ST_EMPTY;
                else if (total == 1)
                begin
                    front_n = 0;
                    back_n = 0;
                end
                else if (op == swad_pkg::OP_POP_FRONT)
                begin
                    if (front_n == 0)
                        split_evenly();
                    front_n--;
                end
                else
                begin
                    if (back_n == 0)
                        split_evenly();
                    back_n--;
                end
            end
            swad_pkg::OP_CLEAR:
            begin
                front_n = 0;
                back_n = 0;
            end
            default:
            begin
            end
        endcase
        r.aggregate = merge(front_fold(), back_fold());
        r.count = swad_pkg::COUNT_W'(front_n + back_n);
        return r;
    endfunction

    task automatic send_op(logic [swad_pkg::OPCODE_W-1:0] op, logic [swad_pkg::DATA_W-1:0] v,
                           bit typed, result_t want);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {5'd0, v, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_deque(op, v);
        if (typed && r != want)
        begin
            $display("%0t table row disagrees: expected %h actual predicted %h", $time, want, r);
            errors++;
        end
        pending_results = {pending_results, r};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (CAP + 20) @(negedge clk);
    endtask

    task automatic set_mode(swad_pkg::mode_t m);
        wait_drained();
        cfg_wr_data <= m;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mode = m;
    endtask

    task automatic set_idling(int sel);
        case (sel)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 59;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 59;
            end
            default:
            begin
                send_idle_pct = 30;
                recv_stall_pct = 30;
            end
        endcase
    endtask

    task automatic random_op();
        logic [swad_pkg::OPCODE_W-1:0] op;
        logic [swad_pkg::DATA_W-1:0]   v;
        int                            pick;
        pick = $urandom_range(99);
        v = $urandom();
        if (pick < 35)
            op = swad_pkg::OP_PUSH_FRONT;
        else if (pick < 70)
            op = swad_pkg::OP_PUSH_BACK;
        else if (pick < 83)
            op = swad_pkg::OP_POP_FRONT;
        else if (pick < 96)
            op = swad_pkg::OP_POP_BACK;
        else if (pick < 98)
            op = swad_pkg::OP_CLEAR;
        else
            op = swad_pkg::OPCODE_W'($urandom_range(7, 5));
        if ($urandom_range(3) == 0)
            v = $urandom_range(15);
        send_op(op, v, 1'b0, '0);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.aggregate = m_axis_tdata[31:0];
            got.count     = m_axis_tdata[42:32];
            got.status    = m_axis_tdata[44:43];
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.aggregate !== want.aggregate)
                begin
                    $display("%0t aggregate: expected %h actual %h", $time,
                             want.aggregate, got.aggregate);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t count: expected %0d actual %0d", $time, want.count, got.count);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t table_rows [$];
        int   wait_cycles;
        errors = 0;
        mode = swad_pkg::MODE_ADD;
        front_n = 0;
        back_n = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        table_rows = '{
            '{swad_pkg::OP_POP_FRONT, 32'h0, 1'b1, '{32'h0, 11'd0, swad_pkg::ST_EMPTY}},
            '{swad_pkg::OP_POP_BACK, 32'h0, 1'b1, '{32'h0, 11'd0, swad_pkg::ST_EMPTY}},
            '{swad_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b1,
              '{32'hFFFF_FFFF, 11'd1, swad_pkg::ST_OK}},
            '{swad_pkg::OP_PUSH_FRONT, 32'h1, 1'b1, '{32'h0, 11'd2, swad_pkg::ST_OK}},
            '{swad_pkg::OP_POP_FRONT, 32'h0, 1'b1, '{32'hFFFF_FFFF, 11'd1, swad_pkg::ST_OK}},
            '{swad_pkg::OP_POP_FRONT, 32'h0, 1'b1, '{32'h0, 11'd0, swad_pkg::ST_OK}},
            '{swad_pkg::OP_PUSH_BACK, 32'h5, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_PUSH_BACK, 32'hA5A5_0000, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_PUSH_BACK, 32'h7, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_PUSH_BACK, 32'h8000_0000, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_POP_FRONT, 32'h0, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_PUSH_FRONT, 32'h3, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_PUSH_FRONT, 32'h5A5A_FFFF, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_POP_BACK, 32'h0, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_POP_BACK, 32'h0, 1'b0, '{'0, '0, '0}},
            '{3'd5, 32'hFFFF_FFFF, 1'b0, '{'0, '0, '0}},
            '{3'd7, 32'h0, 1'b0, '{'0, '0, '0}},
            '{swad_pkg::OP_CLEAR, 32'h0, 1'b1, '{32'h0, 11'd0, swad_pkg::ST_OK}},
            '{3'd6, 32'h0, 1'b1, '{32'h0, 11'd0, swad_pkg::ST_OK}}
        };
        foreach (table_rows[i])
            send_op(table_rows[i].opcode, table_rows[i].value, table_rows[i].typed,
                    table_rows[i].want);

        // Fill to capacity and push past it, then pop from random ends and clear.
        set_mode(swad_pkg::MODE_MAX);
        for (int i = 0; i < CAP; i++)
        begin
            if (i % 256 == 0)
                set_idling(i / 256);
            send_op(i[0] ? swad_pkg::OP_PUSH_FRONT : swad_pkg::OP_PUSH_BACK, $urandom(), 1'b0,
                    '0);
        end
        set_idling(0);
        send_op(swad_pkg::OP_PUSH_BACK, 32'h1234, 1'b0, '0);
        send_op(swad_pkg::OP_PUSH_FRONT, 32'h1234, 1'b0, '0);
        // A mode change while values are held keeps the stored folds.
        set_mode(swad_pkg::MODE_MIN);
        for (int i = 0; i < 60; i++)
            send_op($urandom_range(1) ? swad_pkg::OP_POP_FRONT : swad_pkg::OP_POP_BACK, 0, 1'b0,
                    '0);
        send_op(swad_pkg::OP_CLEAR, 0, 1'b0, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            set_mode(swad_pkg::mode_t'(phase % 4));
            set_idling(phase);
            for (int i = 0; i < 12; i++)
            begin
                random_op();
                if (i == 6 && phase == 3)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(negedge clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (50) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sliding_window_aggregate_deque_unit.f */
design/swad_pkg.sv
design/swad_ram.sv
design/swad_combine.sv
design/sliding_window_aggregate_deque_unit.sv
tb/sliding_window_aggregate_deque_unit_test.sv
